[rtl/weighted_graph_edge_store_top_defines.svh]
// ---------------------------------------------------------------------------
// weighted graph edge store - assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_GRAPH_EDGE_STORE_TOP_DEFINES_SVH
`define WEIGHTED_GRAPH_EDGE_STORE_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define WGES_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("wges: same-cycle check failed");

// next-cycle implication, disabled in reset
`define WGES_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("wges: next-cycle check failed");

`endif

[rtl/wges_pkg.sv]
// ---------------------------------------------------------------------------
// wges_pkg
// shared types and constants of the weighted graph edge store
// ---------------------------------------------------------------------------
`default_nettype none

package wges_pkg;

  localparam int unsigned VertexSlots = 64;
  localparam int unsigned VtxW        = $clog2(VertexSlots);
  localparam int unsigned ArcW        = 2 * VtxW;
  localparam int unsigned WeightW     = 32;
  localparam int unsigned VTotW       = 7;
  localparam int unsigned ETotW       = 12;

  typedef enum logic [2:0] {
    OP_ADD_V = 3'd0,
    OP_ADD_E = 3'd1,
    OP_UPD   = 3'd2,
    OP_REM_E = 3'd3,
    OP_REM_V = 3'd4,
    OP_GET   = 3'd5,
    OP_CONN  = 3'd6,
    OP_CNT   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_V_EXISTS   = 3'd1,
    ST_V_MISSING  = 3'd2,
    ST_SELF_LOOP  = 3'd3,
    ST_E_EXISTS   = 3'd4,
    ST_E_MISSING  = 3'd5,
    ST_W_NOT_POS  = 3'd6
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [VtxW-1:0]    a;
    logic [VtxW-1:0]    b;
    logic [WeightW-1:0] w;
    logic               dir;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [WeightW-1:0] weight;
    logic               conn;
    logic [VTotW-1:0]   vtot;
    logic [ETotW-1:0]   etot;
  } res_t;

endpackage

`default_nettype wire

[rtl/wges_front.sv]
// ---------------------------------------------------------------------------
// wges_front
// command intake: decodes items and holds them in a two-entry queue
// ---------------------------------------------------------------------------
`default_nettype none

module wges_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [2:0]                    func_i,
  input  wire logic [wges_pkg::VtxW-1:0]     vertex_a_i,
  input  wire logic [wges_pkg::VtxW-1:0]     vertex_b_i,
  input  wire logic [wges_pkg::WeightW-1:0]  weight_i,
  input  wire logic                          directed_i,
  output logic                               cmd_vld_o,
  output wges_pkg::cmd_t                     cmd_o,
  input  wire logic                          cmd_take_i
);

  wges_pkg::cmd_t fifo_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  wges_pkg::op_e  op;
  logic           wr_en, rd_en;

  always_comb begin
    unique case (func_i)
      3'd0:    op = wges_pkg::OP_ADD_V;
      3'd1:    op = wges_pkg::OP_ADD_E;
      3'd2:    op = wges_pkg::OP_UPD;
      3'd3:    op = wges_pkg::OP_REM_E;
      3'd4:    op = wges_pkg::OP_REM_V;
      3'd5:    op = wges_pkg::OP_GET;
      3'd6:    op = wges_pkg::OP_CONN;
      default: op = wges_pkg::OP_CNT;
    endcase
  end

  assign full      = cnt_q[1];
  assign cmd_vld_o = (cnt_q != 2'd0);
  assign cmd_o     = fifo_q[rp_q];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_take_i && cmd_vld_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wp_q] <= '{op: op, a: vertex_a_i, b: vertex_b_i, w: weight_i, dir: directed_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wp_q <= ~wp_q;
      if (rd_en) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

`default_nettype wire

[rtl/wges_back.sv]
// ---------------------------------------------------------------------------
// wges_back
// command sequencer with the arc row memory and the weight memory
// ---------------------------------------------------------------------------
`default_nettype none

module wges_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_vld_i,
  input  wire wges_pkg::cmd_t  cmd_i,
  output logic                 cmd_take_o,
  input  wire logic            pop_i,
  output logic                 res_vld_o,
  output wges_pkg::res_t       res_o
);

  localparam int unsigned NV = wges_pkg::VertexSlots;
  localparam int unsigned VW = wges_pkg::VtxW;
  localparam int unsigned WW = wges_pkg::WeightW;
  localparam int unsigned EW = wges_pkg::ETotW;
  localparam int unsigned TW = wges_pkg::VTotW;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_MIR, S_SRD, S_SWR, S_OUT
  } state_e;

  state_e             state_q;
  wges_pkg::cmd_t     cmd_q;
  logic [NV-1:0]      act_q;
  logic [NV-1:0]      row_vld_q;
  logic [TW-1:0]      vt_q;
  logic [EW-1:0]      at_q;
  logic [VW-1:0]      idx_q;
  wges_pkg::status_e  st_q;
  logic [WW-1:0]      wout_q;
  logic               pab_q;
  logic [NV-1:0]      rowa_save_q;
  logic               res_vld_q;
  wges_pkg::res_t     res_q;

  // memories
  logic [NV-1:0]      row_mem [NV];
  logic [WW-1:0]      wt_mem  [NV*NV];
  logic [NV-1:0]      rda_q, rdb_q;
  logic               rva_q, rvb_q;
  logic [WW-1:0]      wrd_q;

  logic [VW-1:0]             ra_addr;
  logic [VW-1:0]             rb_addr;
  logic                      row_we;
  logic [VW-1:0]             row_wa;
  logic [NV-1:0]             row_wd;
  logic                      wt_we;
  logic [wges_pkg::ArcW-1:0] wt_wa;

  logic [NV-1:0]      row_a, row_b, bit_a, bit_b;
  logic               live_a, live_b, both, pab, pba, ok;
  wges_pkg::status_e  ev_st;
  state_e             ev_nxt;
  logic               ev_pab;
  logic               res_free;

  assign row_a  = rva_q ? rda_q : '0;
  assign row_b  = rvb_q ? rdb_q : '0;
  assign bit_a  = NV'(1) << cmd_q.a;
  assign bit_b  = NV'(1) << cmd_q.b;
  assign live_a = act_q[cmd_q.a];
  assign live_b = act_q[cmd_q.b];
  assign both   = live_a && live_b;
  assign pab    = row_a[cmd_q.b];
  assign pba    = row_b[cmd_q.a];
  assign ok     = (ev_st == wges_pkg::ST_OK);

  assign cmd_take_o = (state_q == S_IDLE) && cmd_vld_i;
  assign res_free   = !res_vld_q || pop_i;
  assign res_vld_o  = res_vld_q;
  assign res_o      = res_q;

  always_comb begin
    ev_st = wges_pkg::ST_OK;
    unique case (cmd_q.op)
      wges_pkg::OP_ADD_V: if (live_a) ev_st = wges_pkg::ST_V_EXISTS;
      wges_pkg::OP_ADD_E: begin
        if (!both)                    ev_st = wges_pkg::ST_V_MISSING;
        else if (cmd_q.a == cmd_q.b)  ev_st = wges_pkg::ST_SELF_LOOP;
        else if (pab)                 ev_st = wges_pkg::ST_E_EXISTS;
      end
      wges_pkg::OP_UPD: begin
        if (!both)                              ev_st = wges_pkg::ST_V_MISSING;
        else if (cmd_q.w == '0 || cmd_q.w[WW-1]) ev_st = wges_pkg::ST_W_NOT_POS;
        else if (!pab)                          ev_st = wges_pkg::ST_E_MISSING;
      end
      wges_pkg::OP_REM_E, wges_pkg::OP_GET: begin
        if (!both)     ev_st = wges_pkg::ST_V_MISSING;
        else if (!pab) ev_st = wges_pkg::ST_E_MISSING;
      end
      wges_pkg::OP_REM_V: if (!live_a) ev_st = wges_pkg::ST_V_MISSING;
      wges_pkg::OP_CONN:  if (!both)   ev_st = wges_pkg::ST_V_MISSING;
      default: ev_st = wges_pkg::ST_OK;
    endcase
  end

  // next step and arc flag after evaluation
  always_comb begin
    ev_nxt = S_OUT;
    ev_pab = pab;
    if (ok) begin
      case (cmd_q.op)
        wges_pkg::OP_ADD_E: begin
          ev_pab = 1'b1;
          if (!cmd_q.dir) ev_nxt = S_MIR;
        end
        wges_pkg::OP_UPD: if (!cmd_q.dir && pba) ev_nxt = S_MIR;
        wges_pkg::OP_REM_E: begin
          ev_pab = 1'b0;
          if (!cmd_q.dir && pba) ev_nxt = S_MIR;
        end
        wges_pkg::OP_REM_V: begin
          ev_pab = 1'b0;
          ev_nxt = S_SRD;
        end
        default: ;
      endcase
    end
  end

  // memory port control
  always_comb begin
    ra_addr = (state_q == S_SRD) ? idx_q : cmd_i.a;
    rb_addr = (state_q == S_IDLE) ? cmd_i.b : cmd_q.b;
    row_we  = 1'b0;
    row_wa  = cmd_q.a;
    row_wd  = row_a;
    wt_we   = 1'b0;
    wt_wa   = {cmd_q.a, cmd_q.b};
    unique case (state_q)
      S_EVAL: if (ok) begin
        case (cmd_q.op)
          wges_pkg::OP_ADD_E: begin
            row_we = 1'b1;
            row_wd = row_a | bit_b;
            wt_we  = 1'b1;
          end
          wges_pkg::OP_UPD:   wt_we = 1'b1;
          wges_pkg::OP_REM_E: begin
            row_we = 1'b1;
            row_wd = row_a & ~bit_b;
          end
          default: ;
        endcase
      end
      S_MIR: begin
        row_wa = cmd_q.b;
        wt_wa  = {cmd_q.b, cmd_q.a};
        case (cmd_q.op)
          wges_pkg::OP_ADD_E: begin
            row_we = 1'b1;
            row_wd = row_b | bit_a;
            wt_we  = 1'b1;
          end
          wges_pkg::OP_UPD:   wt_we = 1'b1;
          wges_pkg::OP_REM_E: begin
            row_we = 1'b1;
            row_wd = row_b & ~bit_a;
          end
          default: ;
        endcase
      end
      S_SWR: begin
        row_we = 1'b1;
        row_wa = idx_q;
        row_wd = (idx_q == cmd_q.a) ? '0 : (row_a & ~bit_a);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    rda_q <= row_mem[ra_addr];
    rdb_q <= row_mem[rb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wt_we) wt_mem[wt_wa] <= cmd_q.w;
    wrd_q <= wt_mem[{cmd_i.a, cmd_i.b}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      act_q       <= '0;
      row_vld_q   <= '0;
      rva_q       <= 1'b0;
      rvb_q       <= 1'b0;
      vt_q        <= '0;
      at_q        <= '0;
      idx_q       <= '0;
      st_q        <= wges_pkg::ST_OK;
      wout_q      <= '0;
      pab_q       <= 1'b0;
      rowa_save_q <= '0;
      res_vld_q   <= 1'b0;
      res_q       <= '0;
    end else begin
      rva_q <= row_vld_q[ra_addr];
      rvb_q <= row_vld_q[rb_addr];
      if (row_we) row_vld_q[row_wa] <= 1'b1;
      if (state_q == S_OUT && res_free) res_vld_q <= 1'b1;
      else if (pop_i)                   res_vld_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (cmd_vld_i) begin
          cmd_q   <= cmd_i;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          st_q    <= ev_st;
          wout_q  <= (cmd_q.op == wges_pkg::OP_GET && ok) ? wrd_q : '0;
          pab_q   <= ev_pab;
          state_q <= ev_nxt;
          if (ok) begin
            case (cmd_q.op)
              wges_pkg::OP_ADD_V: begin
                act_q[cmd_q.a] <= 1'b1;
                vt_q <= vt_q + TW'(1);
              end
              wges_pkg::OP_ADD_E: at_q <= at_q + EW'(1);
              wges_pkg::OP_REM_E: at_q <= at_q - EW'(1);
              wges_pkg::OP_REM_V: begin
                rowa_save_q <= row_a;
                idx_q       <= '0;
              end
              default: ;
            endcase
          end
        end
        S_MIR: begin
          if (cmd_q.op == wges_pkg::OP_ADD_E && !pba) at_q <= at_q + EW'(1);
          if (cmd_q.op == wges_pkg::OP_REM_E)         at_q <= at_q - EW'(1);
          state_q <= S_OUT;
        end
        S_SRD: state_q <= S_SWR;
        S_SWR: begin
          // drop column bit of this row and row bit of the removed vertex
          at_q <= at_q - EW'(row_a[cmd_q.a]) - EW'(rowa_save_q[idx_q]);
          if (idx_q == VW'(NV - 1)) begin
            act_q[cmd_q.a] <= 1'b0;
            vt_q    <= vt_q - TW'(1);
            state_q <= S_OUT;
          end else begin
            idx_q   <= idx_q + VW'(1);
            state_q <= S_SRD;
          end
        end
        S_OUT: if (res_free) begin
          res_q.status <= st_q;
          res_q.weight <= wout_q;
          res_q.conn   <= act_q[cmd_q.a] && act_q[cmd_q.b] && pab_q;
          res_q.vtot   <= vt_q;
          res_q.etot   <= cmd_q.dir ? at_q : (at_q >> 1);
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/weighted_graph_edge_store_top.sv]
// ---------------------------------------------------------------------------
// weighted_graph_edge_store_top
// bounded weighted graph store: vertex map plus arc bit and weight matrix
// ---------------------------------------------------------------------------
// usage
//  - command channel: present an item with push; it is taken on a clock edge
//    with push high and full low. a two-entry queue buffers commands
//  - result channel: while empty is low the oldest result sits on the
//    result ports; pop takes it. exactly one result per command
//  - a command passes the sequencer take with row read, evaluate and result
//    load steps, with an undirected mirror write between evaluate and result
//    load where one is needed
//  - remove vertex walks every arc row once, with a read and a write step
//    per row over all 64 rows; this row sweep sets the worst-case rate
//  - the sequencer works on one command at a time: it takes the next one
//    only after the result load step of the previous one, so the take,
//    evaluate and result load steps set the pace
//  - reset clears the vertex map, the counts and the per-row valid flags,
//    so no clearing pass is needed; weights are undefined until written
//  - when the receiver stalls, the result register holds, the sequencer
//    waits and the command queue fills; full then rises
// ---------------------------------------------------------------------------
`default_nettype none

module weighted_graph_edge_store_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command side
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [2:0]                    func_i,
  input  wire logic [wges_pkg::VtxW-1:0]     vertex_a_i,
  input  wire logic [wges_pkg::VtxW-1:0]     vertex_b_i,
  input  wire logic [wges_pkg::WeightW-1:0]  weight_i,
  input  wire logic                          directed_i,
  // result side
  output logic                               empty,
  input  wire logic                          pop,
  output logic [2:0]                         status_o,
  output logic [wges_pkg::WeightW-1:0]       edge_weight_o,
  output logic                               connected_o,
  output logic [wges_pkg::VTotW-1:0]         vertex_total_o,
  output logic [wges_pkg::ETotW-1:0]         edge_total_o
);

  // decoded command between front and sequencer
  wges_pkg::cmd_t cmd;
  logic           cmd_vld, cmd_take;
  // finished result
  wges_pkg::res_t res;
  logic           res_vld;

  wges_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .func_i     (func_i),
    .vertex_a_i (vertex_a_i),
    .vertex_b_i (vertex_b_i),
    .weight_i   (weight_i),
    .directed_i (directed_i),
    .cmd_vld_o  (cmd_vld),
    .cmd_o      (cmd),
    .cmd_take_i (cmd_take)
  );

  wges_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_vld_i  (cmd_vld),
    .cmd_i      (cmd),
    .cmd_take_o (cmd_take),
    .pop_i      (pop),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  // result register drives the ports directly
  assign empty          = !res_vld;
  assign status_o       = res.status;
  assign edge_weight_o  = res.weight;
  assign connected_o    = res.conn;
  assign vertex_total_o = res.vtot;
  assign edge_total_o   = res.etot;

endmodule

`default_nettype wire

[rtl/wges_checker.sv]
// ---------------------------------------------------------------------------
// wges_checker
// port-level checks of the weighted graph edge store
// ---------------------------------------------------------------------------
`default_nettype none
`include "weighted_graph_edge_store_top_defines.svh"

module wges_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic [2:0]                    status_o,
  input wire logic [wges_pkg::WeightW-1:0]  edge_weight_o,
  input wire logic                          connected_o,
  input wire logic [wges_pkg::VTotW-1:0]    vertex_total_o
);

  // a weight is only reported by a successful lookup
  `WGES_ASSERT_IMP(a_wt_ok, clk_i, rst_ni, !empty && edge_weight_o != '0, status_o == wges_pkg::ST_OK)
  // a connected pair cannot report a missing vertex
  `WGES_ASSERT_IMP(a_conn_live, clk_i, rst_ni, !empty && connected_o, status_o != wges_pkg::ST_V_MISSING)
  // vertex count stays within the slots
  `WGES_ASSERT_IMP(a_vtot, clk_i, rst_ni, !empty, vertex_total_o <= wges_pkg::VTotW'(wges_pkg::VertexSlots))
  // a held result stays put until taken
  `WGES_ASSERT_NXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(status_o))

endmodule

bind weighted_graph_edge_store_top wges_checker u_wges_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .status_o       (status_o),
  .edge_weight_o  (edge_weight_o),
  .connected_o    (connected_o),
  .vertex_total_o (vertex_total_o)
);

`default_nettype wire
